[rtl/cfrc_pkg.sv]
package cfrc_pkg;

    localparam int IDENT_W     = 29;
    localparam int EXT_SHIFT   = 18;
    localparam int DATA_BYTES  = 8;
    localparam int MASK_BITS   = 16;

    localparam logic [1:0] FUNC_LOAD_HDR = 2'd0;
    localparam logic [1:0] FUNC_LOAD_OPT = 2'd1;
    localparam logic [1:0] FUNC_CHECK    = 2'd2;

    localparam logic [1:0] DIR_BOTH = 2'd2;

    localparam logic [2:0] OPT_UPPER     = 3'd0;
    localparam logic [2:0] OPT_LOWER     = 3'd1;
    localparam logic [2:0] OPT_FMT_MASK  = 3'd2;
    localparam logic [2:0] OPT_LENGTH    = 3'd3;
    localparam logic [2:0] OPT_FORBIDDEN = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  slot;
        logic [10:0] base_id;
        logic [17:0] ext_id;
        logic        ide;
        logic        rtr;
        logic [1:0]  direction;
        logic [3:0]  count;
        logic [63:0] payload;
        logic [2:0]  option_kind;
        logic [2:0]  byte_first;
        logic [2:0]  byte_last;
    } t_in_word;

    typedef struct packed {
        logic [15:0] violation_mask;
        logic [4:0]  violation_count;
    } t_out_word;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic               ext;
        logic [1:0]         dir;
        logic               req;
        logic [3:0]         nopt;
    } t_rule_hdr;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  first;
        logic [2:0]  last;
        logic [63:0] operand;
    } t_opt_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_RD,
        S_HDR_EV,
        S_OPT,
        S_DONE
    } t_state;

endpackage

[rtl/cfrc_opt_eval.sv]
module cfrc_opt_eval (
    input  cfrc_pkg::t_opt_entry i_opt,
    input  logic [63:0]          i_data,
    input  logic [3:0]           i_dlc,
    output logic                 o_pass
);
    import cfrc_pkg::*;

    logic [63:0] range_mask;
    logic [63:0] range_sum;
    logic        hit;
    logic [3:0]  scan_len;

    // byte j of the sum is simply data byte j when j lies in the range
    always_comb begin
        range_mask = '0;
        hit        = 1'b0;
        scan_len   = (i_dlc > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : i_dlc;
        for (int j = 0; j < DATA_BYTES; j++) begin
            if ((3'(j) >= i_opt.first) && (3'(j) <= i_opt.last)) begin
                range_mask[8*j +: 8] = 8'hff;
            end
            if ((4'(j) < scan_len) && (i_opt.operand[63:8] == '0)
                    && (i_data[8*j +: 8] == i_opt.operand[7:0])) begin
                hit = 1'b1;
            end
        end
        range_sum = i_data & range_mask;
    end

    always_comb begin
        case (i_opt.kind)
            OPT_UPPER:     o_pass = (range_sum <= i_opt.operand);
            OPT_LOWER:     o_pass = (range_sum >= i_opt.operand);
            OPT_FMT_MASK:  o_pass = ((i_data[7:0] & i_opt.operand[7:0]) != 8'd0);
            OPT_LENGTH:    o_pass = ({60'd0, i_dlc} == i_opt.operand);
            OPT_FORBIDDEN: o_pass = !hit;
            default:       o_pass = 1'b1;
        endcase
    end

endmodule

[rtl/can_frame_rule_checker.sv]
// channel | direction | handshake                  | word
// input   | in        | i_in_valid / o_in_ready    | i_in_word (load header, load option, check)
// result  | out       | o_out_valid / i_out_ready  | o_out_word (mask and count)
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (rules in use)
//
// a load word is written into the rule or option memory on accept
// a check walks the rules in use, reading each header and then each option of a matching
// rule through the single read port of each memory; no word is taken while it runs
// a finished result sits in the output register; the next word is taken while it waits,
// but a second check waits in its final state until the register is free
// synchronous active-low reset clears control and the rule count; memories hold
// garbage until written
module can_frame_rule_checker #(
    parameter int RULE_SLOTS       = 16,
    parameter int OPTIONS_PER_RULE = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cfrc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cfrc_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [4:0]          i_cfg_data
);
    import cfrc_pkg::*;

    localparam int OPT_DEPTH = RULE_SLOTS * OPTIONS_PER_RULE;
    localparam int RA = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int OA = (OPT_DEPTH > 1) ? $clog2(OPT_DEPTH) : 1;
    localparam int MAX_CHECK = (RULE_SLOTS < MASK_BITS) ? RULE_SLOTS : MASK_BITS;

    // storage
    t_rule_hdr  hdr_mem [RULE_SLOTS];
    t_opt_entry opt_mem [OPT_DEPTH];
    t_rule_hdr  r_hdr_q;
    t_opt_entry r_opt_q;

    t_state      r_state, n_state;
    logic [4:0]  r_rules_in_use;
    logic [4:0]  r_limit, n_limit;
    logic [4:0]  r_rule, n_rule;
    logic [3:0]  r_k, n_k;
    logic [OA-1:0] r_obase, n_obase;
    logic        r_fail, n_fail;
    logic [15:0] r_mask, n_mask;
    logic [4:0]  r_vcount, n_vcount;
    logic [IDENT_W-1:0] r_ident, n_ident;
    logic        r_ide, n_ide;
    logic        r_rtr, n_rtr;
    logic [1:0]  r_dir, n_dir;
    logic [3:0]  r_dlc, n_dlc;
    logic [63:0] r_data, n_data;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic [RA-1:0] hdr_rd_addr;
    logic [OA-1:0] opt_rd_addr;
    logic          opt_pass;
    logic          in_take;
    logic [IDENT_W-1:0] in_ident;
    logic          hdr_wr, opt_wr;
    logic [6:0]    lim7;
    logic          rule_match;
    logic          out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign in_take     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // identifier as used by both rules and frames
    assign in_ident = i_in_word.ide
        ? IDENT_W'(({18'd0, i_in_word.base_id} << EXT_SHIFT) + {11'd0, i_in_word.ext_id})
        : {18'd0, i_in_word.base_id};

    // a header or option word is written only when its slot lies within its table
    assign hdr_wr = in_take && (i_in_word.func == FUNC_LOAD_HDR)
                    && ({1'b0, i_in_word.slot} < 7'(RULE_SLOTS));
    assign opt_wr = in_take && (i_in_word.func == FUNC_LOAD_OPT)
                    && ({4'd0, i_in_word.slot} < 10'(OPT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (hdr_wr) begin
            hdr_mem[RA'(i_in_word.slot)] <= '{
                ident: in_ident,
                ext:   i_in_word.ide,
                dir:   i_in_word.direction,
                req:   i_in_word.rtr,
                nopt:  (i_in_word.count > 4'(OPTIONS_PER_RULE))
                       ? 4'(OPTIONS_PER_RULE) : i_in_word.count
            };
        end
        r_hdr_q <= hdr_mem[hdr_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (opt_wr) begin
            opt_mem[OA'(i_in_word.slot)] <= '{
                kind:    i_in_word.option_kind,
                first:   i_in_word.byte_first,
                last:    i_in_word.byte_last,
                operand: i_in_word.payload
            };
        end
        r_opt_q <= opt_mem[opt_rd_addr];
    end

    cfrc_opt_eval u_opt_eval (
        .i_opt  (r_opt_q),
        .i_data (r_data),
        .i_dlc  (r_dlc),
        .o_pass (opt_pass)
    );

    // effective rule count, bounded by the table and the mask width
    assign lim7 = ({2'd0, r_rules_in_use} > 7'(MAX_CHECK))
                  ? 7'(MAX_CHECK) : {2'd0, r_rules_in_use};

    assign rule_match = (r_hdr_q.ident == r_ident) && (r_hdr_q.ext == r_ide)
                        && (r_hdr_q.req == r_rtr)
                        && ((r_hdr_q.dir == DIR_BOTH) || (r_hdr_q.dir == r_dir));

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_rule      = r_rule;
        n_k         = r_k;
        n_obase     = r_obase;
        n_fail      = r_fail;
        n_mask      = r_mask;
        n_vcount    = r_vcount;
        n_ident     = r_ident;
        n_ide       = r_ide;
        n_rtr       = r_rtr;
        n_dir       = r_dir;
        n_dlc       = r_dlc;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        hdr_rd_addr = RA'(r_rule);
        opt_rd_addr = OA'(r_obase + OA'(r_k));
        case (r_state)
            S_IDLE: begin
                if (in_take && (i_in_word.func == FUNC_CHECK)) begin
                    n_ident  = in_ident;
                    n_ide    = i_in_word.ide;
                    n_rtr    = i_in_word.rtr;
                    n_dir    = i_in_word.direction;
                    n_dlc    = i_in_word.count;
                    n_data   = i_in_word.payload;
                    n_limit  = lim7[4:0];
                    n_rule   = '0;
                    n_obase  = '0;
                    n_mask   = '0;
                    n_vcount = '0;
                    n_state  = (lim7 == 7'd0) ? S_DONE : S_HDR_RD;
                end
            end
            S_HDR_RD: begin
                n_state = S_HDR_EV;
            end
            S_HDR_EV: begin
                n_fail = 1'b0;
                n_k    = '0;
                if (rule_match && (r_hdr_q.nopt != 4'd0)) begin
                    opt_rd_addr = r_obase;
                    n_state     = S_OPT;
                end else begin
                    n_rule  = r_rule + 5'd1;
                    n_obase = OA'(r_obase + OA'(OPTIONS_PER_RULE));
                    n_state = ((r_rule + 5'd1) == r_limit) ? S_DONE : S_HDR_RD;
                end
            end
            S_OPT: begin
                if ((r_k + 4'd1) < r_hdr_q.nopt) begin
                    n_fail      = r_fail || !opt_pass;
                    n_k         = r_k + 4'd1;
                    opt_rd_addr = OA'(r_obase + OA'(r_k + 4'd1));
                end else begin
                    if (r_fail || !opt_pass) begin
                        n_mask   = r_mask | (16'd1 << r_rule[3:0]);
                        n_vcount = r_vcount + 5'd1;
                    end
                    n_rule  = r_rule + 5'd1;
                    n_obase = OA'(r_obase + OA'(OPTIONS_PER_RULE));
                    n_state = ((r_rule + 5'd1) == r_limit) ? S_DONE : S_HDR_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = '{violation_mask: r_mask, violation_count: r_vcount};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_rules_in_use <= 5'd0;
            r_rule         <= '0;
            r_limit        <= '0;
            r_k            <= '0;
            r_mask         <= '0;
            r_vcount       <= '0;
            r_fail         <= 1'b0;
            r_obase        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rule      <= n_rule;
            r_limit     <= n_limit;
            r_k         <= n_k;
            r_mask      <= n_mask;
            r_vcount    <= n_vcount;
            r_fail      <= n_fail;
            r_obase     <= n_obase;
            if (i_cfg_valid) begin
                r_rules_in_use <= i_cfg_data;
            end
        end
    end

    // frame and result payload
    always_ff @(posedge i_clk) begin
        r_ident <= n_ident;
        r_ide   <= n_ide;
        r_rtr   <= n_rtr;
        r_dir   <= n_dir;
        r_dlc   <= n_dlc;
        r_data  <= n_data;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount == 5'($countones(r_mask)))
        else $error("violation count disagrees with mask");

    a_rule_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR_RD || r_state == S_HDR_EV || r_state == S_OPT)
            |-> (r_rule < r_limit))
        else $error("rule walk beyond limit");

    a_opt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPT) |-> (r_k < r_hdr_q.nopt))
        else $error("option walk beyond option count");

    a_check_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in_word.func == FUNC_CHECK) |=> !o_in_ready)
        else $error("input taken during a check");
`endif

endmodule

[sim/tb_can_frame_rule_checker.sv]
module tb_can_frame_rule_checker;
    import cfrc_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam logic [1:0] DIR_RX      = 2'd0;
    localparam logic [1:0] DIR_TX      = 2'd1;
    localparam logic [1:0] DIR_ODD     = 2'd3;
    localparam logic [2:0] OPT_MESSAGE = 3'd5;
    localparam logic [2:0] OPT_SPARE   = 3'd6;
    localparam logic [2:0] OPT_SPARE_HI = 3'd7;
    localparam int N_RULES  = 16;
    localparam int N_OPTS   = 4;
    localparam int SETTLE   = 150;

    // rule table mirror and queue of expected check outcomes
    class rule_scoreboard;
        t_rule_hdr   hdr[N_RULES];
        t_opt_entry  opt[N_RULES*N_OPTS];
        logic [4:0]  rules_in_use;
        t_out_word   verdict_q[$];
        int          errors;

        function new();
            rules_in_use = '0;
            errors = 0;
        endfunction

        function void note_cfg(logic [4:0] v);
            rules_in_use = v;
        endfunction

        function bit option_ok(t_opt_entry o, logic [63:0] data, logic [3:0] len);
            logic [63:0] sum;
            int n;
            sum = '0;
            case (o.kind)
                OPT_UPPER, OPT_LOWER: begin
                    for (int j = o.first; j <= o.last; j++)
                        sum |= data & (64'hFF << (8*j));
                    return (o.kind == OPT_UPPER) ? (sum <= o.operand) : (sum >= o.operand);
                end
                OPT_FMT_MASK: return ({56'd0, data[7:0]} & o.operand) != 64'd0;
                OPT_LENGTH:   return {60'd0, len} == o.operand;
                OPT_FORBIDDEN: begin
                    n = (len > 4'd8) ? 8 : int'(len);
                    for (int j = 0; j < n; j++)
                        if ({56'd0, data[8*j +: 8]} == o.operand) return 0;
                    return 1;
                end
                default: return 1;
            endcase
        endfunction

        function void note_input(t_in_word w);
            logic [IDENT_W-1:0] id;
            t_out_word v;
            int lim;
            bit ok;
            id = w.ide ? {w.base_id, w.ext_id} : {18'd0, w.base_id};
            case (w.func)
                FUNC_LOAD_HDR: if (w.slot < N_RULES) begin
                    hdr[w.slot] = '{id, w.ide, w.direction, w.rtr,
                                    (w.count > 4'(N_OPTS)) ? 4'(N_OPTS) : w.count};
                end
                FUNC_LOAD_OPT:
                    opt[w.slot] = '{w.option_kind, w.byte_first, w.byte_last, w.payload};
                FUNC_CHECK: begin
                    v = '0;
                    lim = (rules_in_use > N_RULES) ? N_RULES : int'(rules_in_use);
                    for (int i = 0; i < lim; i++) begin
                        if (hdr[i].ident != id || hdr[i].ext != w.ide || hdr[i].req != w.rtr)
                            continue;
                        if (hdr[i].dir != DIR_BOTH && hdr[i].dir != w.direction) continue;
                        ok = 1;
                        for (int k = 0; k < hdr[i].nopt; k++)
                            if (!option_ok(opt[i*N_OPTS+k], w.payload, w.count)) ok = 0;
                        if (!ok) begin
                            v.violation_mask[i] = 1'b1;
                            v.violation_count = v.violation_count + 5'd1;
                        end
                    end
                    verdict_q.push_back(v);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (verdict_q.size() == 0) begin
                $display("%0t: expected no result, actual mask %h count %0d", $time,
                         got.violation_mask, got.violation_count);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.violation_mask !== want.violation_mask) begin
                $display("%0t: mask expected %h actual %h", $time,
                         want.violation_mask, got.violation_mask);
                errors++;
            end
            if (got.violation_count !== want.violation_count) begin
                $display("%0t: count expected %0d actual %0d", $time,
                         want.violation_count, got.violation_count);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_in_valid = 0;
    logic       o_in_ready;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_ready = 0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 0;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    rule_scoreboard sb = new();
    bit calm = 0;        // no idling on either side
    bit hold_req = 0;    // receiver stops taking results for a while

    // identifiers shared by rules and frames so that frames actually hit rules
    logic [10:0] pool_base[4];
    logic [17:0] pool_ext[4];

    can_frame_rule_checker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // results are compared on the edge they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_word);
    end

    // receiver: random stalls, plus one long hold-off while words keep coming
    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (held = 0; held < 1500; held++) @(posedge i_clk);
                hold_req = 0;
            end
            i_out_ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // one word per call; valid stays up into the next word when there is no gap
    task automatic send_word(t_in_word w);
        if (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
    endtask

    // waits for every result, then lets a running check finish before a write
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_rules_in_use(logic [4:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.note_cfg(v);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        w = '0;
        w.base_id     = 11'($urandom);
        w.ext_id      = 18'($urandom);
        w.ide         = 1'($urandom);
        w.rtr         = 1'($urandom);
        w.direction   = 2'($urandom);
        w.count       = 4'($urandom);
        w.payload     = {$urandom, $urandom};
        w.option_kind = 3'($urandom);
        w.byte_first  = 3'($urandom);
        w.byte_last   = 3'($urandom);
        w.slot        = 6'($urandom);
        return w;
    endfunction

    function automatic t_in_word hdr_word(logic [5:0] slot, logic [10:0] b, logic [17:0] e,
                                          logic ide, logic rtr, logic [1:0] dir,
                                          logic [3:0] n);
        t_in_word w;
        w = rand_word();
        w.func = FUNC_LOAD_HDR; w.slot = slot; w.base_id = b; w.ext_id = e;
        w.ide = ide; w.rtr = rtr; w.direction = dir; w.count = n;
        return w;
    endfunction

    function automatic t_in_word opt_word(logic [5:0] slot, logic [2:0] kind,
                                          logic [2:0] f, logic [2:0] l, logic [63:0] op);
        t_in_word w;
        w = rand_word();
        w.func = FUNC_LOAD_OPT; w.slot = slot; w.option_kind = kind;
        w.byte_first = f; w.byte_last = l; w.payload = op;
        return w;
    endfunction

    function automatic t_in_word frame_word(logic [10:0] b, logic [17:0] e, logic ide,
                                            logic rtr, logic [1:0] dir, logic [3:0] len,
                                            logic [63:0] data);
        t_in_word w;
        w = rand_word();
        w.func = FUNC_CHECK; w.base_id = b; w.ext_id = e; w.ide = ide; w.rtr = rtr;
        w.direction = dir; w.count = len; w.payload = data;
        return w;
    endfunction

    // random word, mostly frames aimed at known identifiers
    function automatic t_in_word pick_word();
        t_in_word w;
        int r, p;
        logic [63:0] op;
        w = rand_word();
        r = $urandom_range(99);
        p = $urandom_range(3);
        case ($urandom_range(3))
            0: op = {$urandom, $urandom};
            1: op = 64'($urandom_range(255));
            2: op = 64'($urandom_range(15));
            default: op = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        if (r < 12) begin
            w.func = FUNC_LOAD_HDR;
            if ($urandom_range(9) < 8) w.slot = 6'($urandom_range(N_RULES-1));
            if ($urandom_range(9) < 8) begin
                w.base_id = pool_base[p];
                w.ext_id  = pool_ext[p];
            end
        end else if (r < 35) begin
            w.func = FUNC_LOAD_OPT;
            w.payload = op;
        end else if (r < 38) begin
            w.func = FUNC_NONE;
        end else begin
            w.func = FUNC_CHECK;
            if ($urandom_range(9) < 8) begin
                w.base_id = pool_base[p];
                w.ext_id  = pool_ext[p];
            end
            if ($urandom_range(3) == 0) w.payload[8*$urandom_range(7) +: 8] = op[7:0];
        end
        return w;
    endfunction

    initial begin
        logic [4:0] phase_rules[6] = '{5'd16, 5'd31, 5'd3, 5'd17, 5'd1, 5'd16};
        for (int i = 0; i < 4; i++) begin
            pool_base[i] = 11'($urandom);
            pool_ext[i]  = 18'($urandom);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing in use yet: checks read no table entry
        write_rules_in_use(5'd0);
        send_word(frame_word(11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_ODD, 4'hF, '1));
        send_word(frame_word(11'h000, 18'h00000, 1'b0, 1'b0, DIR_RX, 4'h0, '0));
        send_word(hdr_word(6'd63, 11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_ODD, 4'hF)); // ignored slot
        send_word(hdr_word(6'd16, 11'h001, 18'h00001, 1'b0, 1'b0, DIR_TX, 4'h1));  // ignored slot
        begin
            t_in_word w;
            w = rand_word();
            w.func = FUNC_NONE;
            send_word(w);
        end

        // fill the whole table before any rule is looked at
        for (int i = 0; i < N_RULES; i++) begin
            t_in_word w;
            w = pick_word();
            w.func = FUNC_LOAD_HDR;
            w.slot = 6'(i);
            send_word(w);
        end
        for (int s = 0; s < N_RULES*N_OPTS; s++) begin
            t_in_word w;
            w = pick_word();
            w.func = FUNC_LOAD_OPT;
            w.slot = 6'(s);
            send_word(w);
        end
        drain();

        // directed rules: every option kind, reversed range, odd direction
        write_rules_in_use(5'd16);
        send_word(hdr_word(6'd0, 11'h123, 18'h0, 1'b0, 1'b0, DIR_BOTH, 4'd4));
        send_word(opt_word(6'd0, OPT_UPPER, 3'd0, 3'd1, 64'h0100));
        send_word(opt_word(6'd1, OPT_LOWER, 3'd5, 3'd2, 64'h0));
        send_word(opt_word(6'd2, OPT_FMT_MASK, 3'd0, 3'd0, 64'h0F));
        send_word(opt_word(6'd3, OPT_LENGTH, 3'd0, 3'd0, 64'd2));
        send_word(hdr_word(6'd1, 11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_TX, 4'd15));
        send_word(opt_word(6'd4, OPT_FORBIDDEN, 3'd0, 3'd7, 64'hAA));
        send_word(opt_word(6'd5, OPT_MESSAGE, 3'd0, 3'd0, '1));
        send_word(opt_word(6'd6, OPT_SPARE, 3'd7, 3'd0, '1));
        send_word(opt_word(6'd7, OPT_SPARE_HI, 3'd0, 3'd7, 64'h1));
        send_word(hdr_word(6'd2, 11'h123, 18'h0, 1'b0, 1'b0, DIR_ODD, 4'd1));
        send_word(frame_word(11'h123, 18'h0, 1'b0, 1'b0, DIR_RX, 4'd2, 64'h00FF));
        send_word(frame_word(11'h123, 18'h0, 1'b0, 1'b0, DIR_TX, 4'd3, 64'h0301));
        send_word(frame_word(11'h123, 18'h0, 1'b0, 1'b0, DIR_ODD, 4'd2, 64'h10));
        send_word(frame_word(11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_TX, 4'd15, {8{8'h55}}));
        send_word(frame_word(11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_TX, 4'd9,
                             64'hAA00_0000_0000_0000));
        send_word(frame_word(11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_TX, 4'd7,
                             64'hAA00_0000_0000_0000));
        send_word(frame_word(11'h7FF, 18'h3FFFF, 1'b1, 1'b1, DIR_RX, 4'd8, 64'hAA));
        drain();

        // random phases across several rule counts, the extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            write_rules_in_use(phase_rules[ph]);
            calm = (ph == 3);
            for (int n = 0; n < 250; n++) begin
                if (ph == 1 && n == 20) hold_req = 1;
                send_word(pick_word());
            end
            drain();
        end
        calm = 0;

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
